// ----- hw/rtl/adsr_pkg.sv -----
package adsr_pkg;

    localparam int DUR_W      = 24;
    localparam int LVL_W      = 16;
    localparam int QUOT_W     = 17;
    localparam int OP_W       = 2;
    localparam int IN_TIME_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [LVL_W-1:0] FULL_SCALE = 16'h8000;
    localparam logic [LVL_W-1:0] FLOOR_LSB  = 16'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE   = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

    // Status handed from the multiply-divide unit to the sequencer.
    typedef struct packed {
        logic done;
        logic sat;
    } mdu_status_t;

endpackage

// ----- hw/rtl/adsr_mdu.sv -----
module adsr_mdu #(
    parameter int NUM_W = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num_in,
    input  logic [adsr_pkg::LVL_W-1:0]    mag_in,
    input  logic [adsr_pkg::DUR_W-1:0]    den_in,
    output logic [adsr_pkg::QUOT_W-1:0]   quot_out,
    output adsr_pkg::mdu_status_t         status
);
    import adsr_pkg::*;

    localparam int PW    = NUM_W + LVL_W;
    localparam int HW    = PW - QUOT_W;
    localparam int CW    = (HW > DUR_W) ? HW : DUR_W;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam int TR_W  = DUR_W + 2;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_MUL  = 4'b0010,
        PH_CHK  = 4'b0100,
        PH_DIV  = 4'b1000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [LVL_W-1:0]    mag_reg, mag_next;
    logic [DUR_W-1:0]    den_reg, den_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [DUR_W-1:0]    rem_reg, rem_next;
    logic [QUOT_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    mdu_status_t         status_reg, status_next;
    logic [TR_W-1:0]     trial;

    // One restoring step: shift the next dividend bit into the remainder and
    // try to take the divisor away.
    assign trial = {1'b0, rem_reg, quo_reg[QUOT_W-1]} - {2'b00, den_reg};

    always_comb begin
        phase_next  = phase_reg;
        num_next    = num_reg;
        mag_next    = mag_reg;
        den_next    = den_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        status_next = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    num_next   = num_in;
                    mag_next   = mag_in;
                    den_next   = den_in;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL: begin
                prod_next  = PW'(num_reg) * PW'(mag_reg);
                phase_next = PH_CHK;
            end
            PH_CHK: begin
                // A quotient that needs more than QUOT_W bits is only ever
                // clipped to full scale afterwards, so it is flagged instead.
                if (CW'(prod_reg[PW-1:QUOT_W]) >= CW'(den_reg)) begin
                    status_next.done = 1'b1;
                    status_next.sat  = 1'b1;
                    phase_next       = PH_IDLE;
                end else begin
                    rem_next   = DUR_W'(prod_reg[PW-1:QUOT_W]);
                    quo_next   = prod_reg[QUOT_W-1:0];
                    cnt_next   = '0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV: begin
                if (!trial[TR_W-1]) begin
                    rem_next = trial[DUR_W-1:0];
                end else begin
                    rem_next = {rem_reg[DUR_W-2:0], quo_reg[QUOT_W-1]};
                end
                quo_next = {quo_reg[QUOT_W-2:0], ~trial[TR_W-1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    status_next.done = 1'b1;
                    phase_next       = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            status_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            status_reg <= status_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        mag_reg  <= mag_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign quot_out = quo_reg;
    assign status   = status_reg;

endmodule

// ----- hw/rtl/adsr_envelope_generator.sv -----
// Linear ADSR envelope generator.
// Input channel (s_): one beat per item. s_tuser carries the operation
// (sample request, note on, note off) and s_tdata the time in sample ticks.
// Note on and note off take effect in the cycle they are accepted and give
// no result. A sample request gives one beat on the result channel (m_),
// m_tdata holding the amplitude in Q1.15, 0 to 32768.
// Configuration channel (cfg_): one register write per beat, always ready;
// write only while no sample request is in progress.
// Steps of a sample request: time subtraction and compare (ST_DIFF, ST_SUB,
// ST_CLASS); then either the level follows without arithmetic (before the
// attack, sustain hold, release finished), or the shared unit multiplies,
// checks the range (a quotient that overflows skips the division and
// saturates) and takes 17 steps of its restoring divider, hands the quotient
// back, and the final add and clip follow. s_tready is low for that whole
// time, so a new item is taken only once the sample request is through.
// The result sits in an output register; while the receiver stalls
// the block keeps taking note items, and a finished sample request waits
// until that register is free.
// Reset restores the default durations and levels, clears both trigger
// times and the gate, and empties the output register.
module adsr_envelope_generator #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adsr_pkg::IN_TIME_W-1:0]    s_tdata,   // [31:0] time_ticks
    input  logic [adsr_pkg::OP_W-1:0]         s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adsr_pkg::LVL_W-1:0]        m_tdata,   // [15:0] amplitude
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adsr_pkg::*;

    localparam int TW = (TIME_WIDTH < IN_TIME_W) ? TIME_WIDTH : IN_TIME_W;
    localparam int DW = TW + 1;
    localparam int EW = ((DW > DUR_W + 1) ? DW : DUR_W + 1) + 1;
    localparam int SW = QUOT_W + 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DIFF  = 6'b000010,
        ST_SUB   = 6'b000100,
        ST_CLASS = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [DUR_W-1:0]    attack_reg, attack_next;
    logic [DUR_W-1:0]    decay_reg, decay_next;
    logic [DUR_W-1:0]    release_reg, release_next;
    logic [LVL_W-1:0]    start_reg, start_next;
    logic [LVL_W-1:0]    sustain_reg, sustain_next;
    logic [TW-1:0]       trig_on_reg, trig_on_next;
    logic [TW-1:0]       trig_off_reg, trig_off_next;
    logic                gate_reg, gate_next;
    logic [TW-1:0]       now_reg, now_next;
    logic [DW-1:0]       diff_reg, diff_next;
    logic [EW-1:0]       rel_reg, rel_next;
    logic [LVL_W-1:0]    base_reg, base_next;
    logic                add_reg, add_next;
    logic [QUOT_W-1:0]   q_reg, q_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [LVL_W-1:0]    m_tdata_reg, m_tdata_next;

    logic [DUR_W-1:0]    at_eff, dt_eff, rt_eff;
    logic [LVL_W-1:0]    st_eff, su_eff, lvl_gap;
    logic [LVL_W:0]      gap_signed;
    logic                diff_neg, rel_nonpos, decay_in;
    logic [DW-1:0]       diff_abs_full;
    logic [TW-1:0]       diff_abs;

    logic                mdu_start;
    logic [TW-1:0]       op_num;
    logic [LVL_W-1:0]    op_mag;
    logic [DUR_W-1:0]    op_den;
    logic                op_direct;
    logic [LVL_W-1:0]    op_value;
    logic [LVL_W-1:0]    op_base;
    logic                op_add;
    logic [QUOT_W-1:0]   mdu_quot;
    mdu_status_t         mdu_status;

    logic [SW-1:0]       level_sum;
    logic [LVL_W-1:0]    level_out;
    logic                s_fire, out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // A duration of zero counts as one tick; levels clip at full scale.
    assign at_eff = (attack_reg == '0) ? DUR_W'(1) : attack_reg;
    assign dt_eff = (decay_reg == '0) ? DUR_W'(1) : decay_reg;
    assign rt_eff = (release_reg == '0) ? DUR_W'(1) : release_reg;
    assign st_eff = (start_reg > FULL_SCALE) ? FULL_SCALE : start_reg;
    assign su_eff = (sustain_reg > FULL_SCALE) ? FULL_SCALE : sustain_reg;

    assign gap_signed    = {1'b0, su_eff} - {1'b0, st_eff};
    assign lvl_gap       = gap_signed[LVL_W] ? LVL_W'(-gap_signed) : gap_signed[LVL_W-1:0];
    assign diff_neg      = diff_reg[DW-1];
    assign diff_abs_full = diff_neg ? (-diff_reg) : diff_reg;
    assign diff_abs      = diff_abs_full[TW-1:0];
    assign rel_nonpos    = rel_reg[EW-1] || (rel_reg == '0);
    assign decay_in      = $signed(rel_reg) <= $signed({{(EW-DUR_W){1'b0}}, dt_eff});

    // Pick the segment of the envelope and the operands for the shared unit.
    always_comb begin
        op_num    = diff_abs;
        op_mag    = st_eff;
        op_den    = at_eff;
        op_direct = 1'b0;
        op_value  = '0;
        op_base   = '0;
        op_add    = 1'b1;
        if (gate_reg) begin
            if (diff_neg) begin
                op_direct = 1'b1;
            end else if (rel_nonpos) begin
                op_num = diff_abs;
            end else if (decay_in) begin
                op_num  = rel_reg[TW-1:0];
                op_mag  = lvl_gap;
                op_den  = dt_eff;
                op_base = st_eff;
                op_add  = !gap_signed[LVL_W];
            end else begin
                op_direct = 1'b1;
                op_value  = su_eff;
            end
        end else begin
            op_mag  = su_eff;
            op_den  = rt_eff;
            op_base = su_eff;
            if (!rel_reg[EW-1]) begin
                op_direct = 1'b1;
            end else begin
                // Before the release point the level rises above sustain.
                op_add = diff_neg;
            end
        end
    end

    assign mdu_start = (state_reg == ST_CLASS) && !op_direct;

    adsr_mdu #(
        .NUM_W (TW)
    ) u_mdu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mdu_start),
        .num_in   (op_num),
        .mag_in   (op_mag),
        .den_in   (op_den),
        .quot_out (mdu_quot),
        .status   (mdu_status)
    );

    always_comb begin
        if (add_reg) begin
            level_sum = {{(SW-LVL_W){1'b0}}, base_reg} + {{(SW-QUOT_W){1'b0}}, q_reg};
        end else begin
            level_sum = {{(SW-LVL_W){1'b0}}, base_reg} - {{(SW-QUOT_W){1'b0}}, q_reg};
        end
        if ($signed(level_sum) <= $signed({{(SW-LVL_W){1'b0}}, FLOOR_LSB})) begin
            level_out = '0;
        end else if ($signed(level_sum) > $signed({{(SW-LVL_W){1'b0}}, FULL_SCALE})) begin
            level_out = FULL_SCALE;
        end else begin
            level_out = level_sum[LVL_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        attack_next   = attack_reg;
        decay_next    = decay_reg;
        release_next  = release_reg;
        start_next    = start_reg;
        sustain_next  = sustain_reg;
        trig_on_next  = trig_on_reg;
        trig_off_next = trig_off_reg;
        gate_next     = gate_reg;
        now_next      = now_reg;
        diff_next     = diff_reg;
        rel_next      = rel_reg;
        base_next     = base_reg;
        add_next      = add_reg;
        q_next        = q_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ATTACK:  attack_next  = cfg_data[DUR_W-1:0];
                CFG_DECAY:   decay_next   = cfg_data[DUR_W-1:0];
                CFG_RELEASE: release_next = cfg_data[DUR_W-1:0];
                CFG_START:   start_next   = cfg_data[LVL_W-1:0];
                CFG_SUSTAIN: sustain_next = cfg_data[LVL_W-1:0];
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        OP_SAMPLE: begin
                            now_next   = s_tdata[TW-1:0];
                            state_next = ST_DIFF;
                        end
                        OP_NOTE_ON: begin
                            trig_on_next = s_tdata[TW-1:0];
                            gate_next    = 1'b1;
                        end
                        OP_NOTE_OFF: begin
                            trig_off_next = s_tdata[TW-1:0];
                            gate_next     = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIFF: begin
                diff_next  = {1'b0, now_reg} - {1'b0, gate_reg ? trig_on_reg : trig_off_reg};
                state_next = ST_SUB;
            end
            ST_SUB: begin
                rel_next = {{(EW-DW){diff_reg[DW-1]}}, diff_reg}
                         - {{(EW-DUR_W){1'b0}}, gate_reg ? at_eff : rt_eff};
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                if (op_direct) begin
                    base_next  = op_value;
                    add_next   = 1'b1;
                    q_next     = '0;
                    state_next = ST_FIN;
                end else begin
                    base_next  = op_base;
                    add_next   = op_add;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (mdu_status.done) begin
                    q_next     = mdu_status.sat ? '1 : mdu_quot;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = level_out;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            attack_reg   <= DUR_W'(441);
            decay_reg    <= DUR_W'(44100);
            release_reg  <= DUR_W'(44100);
            start_reg    <= FULL_SCALE;
            sustain_reg  <= '0;
            trig_on_reg  <= '0;
            trig_off_reg <= '0;
            gate_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            attack_reg   <= attack_next;
            decay_reg    <= decay_next;
            release_reg  <= release_next;
            start_reg    <= start_next;
            sustain_reg  <= sustain_next;
            trig_on_reg  <= trig_on_next;
            trig_off_reg <= trig_off_next;
            gate_reg     <= gate_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        diff_reg    <= diff_next;
        rel_reg     <= rel_next;
        base_reg    <= base_next;
        add_reg     <= add_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ----- hw/rtl/adsr_checker.sv -----
module adsr_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [adsr_pkg::OP_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [adsr_pkg::LVL_W-1:0]     m_tdata
);
    import adsr_pkg::*;

    // A stalled result beat keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Amplitudes lie in range and never sit in the floored band.
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == '0) || ((m_tdata > FLOOR_LSB) && (m_tdata <= FULL_SCALE)))
        else $error("amplitude out of range");

    // A sample request keeps the block busy, so the input is not ready straight after it.
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_SAMPLE) |=> !s_tready)
        else $error("input ready straight after a sample request");

    // Note items complete in the cycle they are taken.
    a_note_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_SAMPLE) |=> s_tready)
        else $error("input not ready after a note item");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat offered after reset");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import adsr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int DIR_ROWS        = 34;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [OP_W-1:0]       op;
        logic [IN_TIME_W-1:0]  t;
        bit                    known;
        logic [LVL_W-1:0]      amp;
    } dir_row_t;

    // Rows with known set carry an amplitude that follows directly from the
    // envelope definition; the others are checked against the predictor.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd0,         1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_UNUSED,   32'd5,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_NOTE_ON,  32'd1000,      1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd999,       1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1000,      1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1441,      1'b1, 16'd32768},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1220,      1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd20000,     1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'hFFFF_FFFF, 1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_NOTE_OFF, 32'd50000,     1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd50000,     1'b1, 16'd0},
        '{1'b1, CFG_SUSTAIN, 24'hFFFFFF, OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b1, CFG_RELEASE, 24'd0,      OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd50000,     1'b1, 16'd32768},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd50001,     1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd49999,     1'b1, 16'd32768},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd0,         1'b1, 16'd32768},
        '{1'b1, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b1, CFG_DECAY,   24'hFFFFFF, OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b1, CFG_SUSTAIN, 24'd20000,  OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_NOTE_ON,  32'hFFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd0,         1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'hFFFF_FFFF, 1'b1, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_NOTE_ON,  32'd0,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1,         1'b1, 16'd32768},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd2,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd16777216,  1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'hFFFF_FFF0, 1'b0, 16'd0},
        '{1'b1, CFG_START,   24'd3,      OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1,         1'b1, 16'd0},
        '{1'b1, CFG_START,   24'd4,      OP_SAMPLE,   32'd0,         1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd1,         1'b1, 16'd4},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_NOTE_OFF, 32'hFFFF_FFFF, 1'b0, 16'd0},
        '{1'b0, CFG_ATTACK,  24'd0,      OP_SAMPLE,   32'd0,         1'b0, 16'd0}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TIME_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [LVL_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and note state.
    logic [DUR_W-1:0] atk_ticks = 24'd441;
    logic [DUR_W-1:0] dcy_ticks = 24'd44100;
    logic [DUR_W-1:0] rel_ticks = 24'd44100;
    logic [LVL_W-1:0] peak_lvl  = FULL_SCALE;
    logic [LVL_W-1:0] hold_lvl  = '0;
    logic [31:0]      on_time   = '0;
    logic [31:0]      off_time  = '0;
    bit               gate_on   = 1'b0;

    logic [LVL_W-1:0] amp_queue [$];
    int               bad_beats  = 0;
    int               burst_left = 0;
    logic [7:0]       stall_pat  = 8'hFF;
    logic [5:0]       stall_tick = '0;

    adsr_envelope_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("FAIL adsr_envelope_generator");
        $finish;
    end

    function automatic logic [LVL_W-1:0] envelope_level(input logic [31:0] now);
        longint st, su, at, dt, rt, life, lev;
        st = (peak_lvl > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(peak_lvl);
        su = (hold_lvl > FULL_SCALE) ? longint'(FULL_SCALE) : longint'(hold_lvl);
        at = (atk_ticks == 0) ? 64'sd1 : longint'(atk_ticks);
        dt = (dcy_ticks == 0) ? 64'sd1 : longint'(dcy_ticks);
        rt = (rel_ticks == 0) ? 64'sd1 : longint'(rel_ticks);
        if (gate_on) begin
            life = longint'(now) - longint'(on_time);
            if (life < 0)
                lev = 0;
            else if (life <= at)
                lev = (life * st) / at;
            else if (life - at <= dt) begin
                if (su >= st)
                    lev = st + ((life - at) * (su - st)) / dt;
                else
                    lev = st - ((life - at) * (st - su)) / dt;
            end else
                lev = su;
        end else begin
            life = longint'(now) - longint'(off_time);
            if (life >= rt)
                lev = 0;
            else if (life >= 0)
                lev = su - (life * su) / rt;
            else
                lev = su + ((-life) * su) / rt;
        end
        if (lev > longint'(FULL_SCALE))
            lev = longint'(FULL_SCALE);
        if (lev <= longint'(FLOOR_LSB))
            lev = 0;
        return LVL_W'(lev);
    endfunction

    // Offsets around a segment boundary, with a few far away and a few just before.
    function automatic logic [31:0] pick_offset(input int unsigned span);
        case ($urandom_range(8))
            0: return -32'($urandom_range(1, 3));
            1: return 32'd0;
            2: return 32'(span);
            3: return 32'(span + 1);
            4: return 32'(span - 1);
            5: return $urandom;
            default: return 32'($urandom_range(span + 2));
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [31:0] t,
                             input bit known = 1'b0, input logic [LVL_W-1:0] amp = '0);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= t;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        case (op)
            OP_SAMPLE:   amp_queue.push_back(known ? amp : envelope_level(t));
            OP_NOTE_ON:  begin on_time = t; gate_on = 1'b1; end
            OP_NOTE_OFF: begin off_time = t; gate_on = 1'b0; end
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ATTACK:  atk_ticks = data;
            CFG_DECAY:   dcy_ticks = data;
            CFG_RELEASE: rel_ticks = data;
            CFG_START:   peak_lvl  = data[LVL_W-1:0];
            CFG_SUSTAIN: hold_lvl  = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    // Hold the sender off until every amplitude has come back and the block
    // has had time to finish whatever it was doing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (amp_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input int mode);
        logic [CFG_DATA_W-1:0] d;
        logic [LVL_W-1:0]      lv;
        for (int i = 0; i < 5; i++) begin
            if (mode == 0)
                d = 24'hFFFFFF;
            else if (mode == 1)
                d = '0;
            else if (i < 3) begin
                case ($urandom_range(9))
                    0: d = '0;
                    1: d = 24'hFFFFFF;
                    2: d = 24'($urandom);
                    default: d = 24'($urandom_range(1, 200));
                endcase
            end else begin
                case ($urandom_range(7))
                    0: lv = '0;
                    1: lv = FULL_SCALE;
                    2: lv = 16'($urandom_range(32769, 65535));
                    3: lv = 16'($urandom_range(1, 5));
                    default: lv = 16'($urandom_range(32768));
                endcase
                d = {8'($urandom), lv};
            end
            write_reg(CFG_IDX_W'(i), d);
        end
        // Indexes past the last register must be ignored.
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'(CFG_SUSTAIN + 1 + $urandom_range(2)), 24'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items);
        int unsigned at_e, dt_e, rt_e;
        int          done_items, n;
        logic [31:0] base, rel_at;
        at_e = (atk_ticks == 0) ? 1 : atk_ticks;
        dt_e = (dcy_ticks == 0) ? 1 : dcy_ticks;
        rt_e = (rel_ticks == 0) ? 1 : rel_ticks;
        done_items = 0;
        while (done_items < n_items) begin
            case ($urandom_range(11))
                0: begin
                    send_item(OP_W'($urandom), $urandom);
                    done_items++;
                end
                1: begin
                    if ($urandom_range(3) == 0)
                        settle();
                end
                default: begin
                    base = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(300)
                                                    : $urandom;
                    send_item(OP_NOTE_ON, base);
                    n = $urandom_range(2, 8);
                    repeat (n)
                        send_item(OP_SAMPLE, base + pick_offset(
                            ($urandom_range(1) == 0) ? at_e : at_e + dt_e));
                    done_items += n + 1;
                    if ($urandom_range(3) != 0) begin
                        rel_at = base + pick_offset(at_e + dt_e);
                        send_item(OP_NOTE_OFF, rel_at);
                        n = $urandom_range(2, 6);
                        repeat (n)
                            send_item(OP_SAMPLE, rel_at + pick_offset(rt_e));
                        done_items += n + 1;
                    end
                end
            endcase
        end
    endtask

    // Receiver back-pressure: a rotating 8-bit pattern, reloaded whenever the 6-bit tick counter wraps.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick == 6'd63)
            stall_pat <= ($urandom_range(3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        else
            stall_pat <= {stall_pat[0], stall_pat[7:1]};
        m_tready <= stall_pat[0];
    end

    always @(posedge aclk) begin : amp_check
        logic [LVL_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (amp_queue.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("%0t: amplitude beat %0d with none expected", $realtime, m_tdata);
            end else begin
                want = amp_queue.pop_front();
                if (m_tdata !== want) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t: amplitude mismatch, expected %0d, got %0d",
                                 $realtime, want, m_tdata);
                end
            end
        end
    end

    initial begin : stimulus
        while (!aresetn) @(posedge aclk);
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].is_cfg) begin
                settle();
                write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].data);
                cfg_valid <= 1'b0;
            end else begin
                send_item(DIR_TABLE[r].op, DIR_TABLE[r].t, DIR_TABLE[r].known,
                          DIR_TABLE[r].amp);
            end
        end
        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_config(p);
            run_phase(ITEMS_PER_PHASE);
        end
        settle();
        if (bad_beats == 0 && amp_queue.size() == 0)
            $display("PASS adsr_envelope_generator");
        else
            $display("FAIL adsr_envelope_generator");
        $finish;
    end

endmodule

// ----- adsr_envelope_generator.f -----
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_mdu.sv
hw/rtl/adsr_envelope_generator.sv
hw/rtl/adsr_checker.sv
bench/tb_top.sv
